// ===== rtl/core/hbt_pkg.sv =====
package hbt_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 16;
  localparam int unsigned BUCKET_WAYS_DEF = 8;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned BIDX_W  = 4;
  localparam int unsigned COUNT_W = 8;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Remainder unit: bits of the key consumed per cycle
  localparam int unsigned MOD_STEP_BITS = 8;
  localparam int unsigned MOD_CYCLES    = KEY_W / MOD_STEP_BITS;
  localparam int unsigned MOD_CNT_W     = $clog2(MOD_CYCLES);

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CMP
  } hbt_state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd_fast;
    logic rd;
    logic mod_step;
    logic commit;
  } hbt_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic fast;
    logic mod_done;
    logic out_stall;
  } hbt_sts_t;

endpackage

// ===== rtl/core/hbt_ram.sv =====
module hbt_ram import hbt_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hbt_ctrl.sv =====
module hbt_ctrl import hbt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hbt_sts_t sts_i,
  output hbt_cmd_t cmd_o
);

  hbt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = sts_i.fast ? ST_CMP : ST_MOD;
      end
      ST_MOD: begin
        if (sts_i.mod_done) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // hold until the result register can take the new transaction
        if (!sts_i.out_stall) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i;
        cmd_o.rd_fast = in_valid_i;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_CMP: begin
        cmd_o.commit = !sts_i.out_stall;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  ap_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.out_stall)
    else $error("commit while result register is stalled");

  ap_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_o.load && !cmd_o.commit)
    else $error("operation during clearing pass");

  ap_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> (state_q == ST_CMP))
    else $error("row read not followed by compare");

endmodule

// ===== rtl/core/hbt_dp.sv =====
module hbt_dp import hbt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_WAYS = BUCKET_WAYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbt_cmd_t           cmd_i,
  output hbt_sts_t           sts_o,
  input  logic               in_func_i,
  input  logic [KEY_W-1:0]   in_key_i,
  input  logic [VAL_W-1:0]   in_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_hit_o,
  output logic [VAL_W-1:0]   out_read_value_o,
  output logic               out_rejected_o,
  output logic [BIDX_W-1:0]  out_bucket_index_o,
  output logic [COUNT_W-1:0] out_entries_stored_o
);

  localparam int unsigned BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int unsigned FILL_W  = $clog2(BUCKET_WAYS + 1);
  localparam int unsigned SLOTS   = NUM_BUCKETS * BUCKET_WAYS;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned VOFF    = BUCKET_WAYS * KEY_W;
  localparam int unsigned FOFF    = VOFF + BUCKET_WAYS * VAL_W;
  localparam int unsigned ROW_W   = FOFF + FILL_W;
  localparam bit          BKT_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

  // Operation registers
  logic             func_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_func_i;
      key_q   <= in_key_i;
      value_q <= in_value_i;
    end
  end

  // Bucket selection
  logic [BKT_W-1:0] bkt_in;
  logic [BKT_W-1:0] bkt_cur;

  if (BKT_POW2) begin : g_mask
    logic [BKT_W-1:0] bkt_q;
    assign bkt_in = (NUM_BUCKETS > 1) ? in_key_i[BKT_W-1:0] : '0;
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) bkt_q <= bkt_in;
    end
    assign bkt_cur        = bkt_q;
    assign sts_o.fast     = 1'b1;
    assign sts_o.mod_done = 1'b1;
  end else begin : g_rem
    logic [BKT_W-1:0]     rem_q, rem_d;
    logic [KEY_W-1:0]     sh_q;
    logic [MOD_CNT_W-1:0] cnt_q;

    // Restoring remainder, one key bit per step, MSB first
    always_comb begin
      logic [BKT_W:0] r;
      r = {1'b0, rem_q};
      for (int b = 0; b < MOD_STEP_BITS; b++) begin
        r = {r[BKT_W-1:0], sh_q[KEY_W-1-b]};
        if (r >= (BKT_W+1)'(NUM_BUCKETS)) r = r - (BKT_W+1)'(NUM_BUCKETS);
      end
      rem_d = r[BKT_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= '0;
      end else if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        rem_q <= '0;
        sh_q  <= in_key_i;
      end else if (cmd_i.mod_step) begin
        rem_q <= rem_d;
        sh_q  <= sh_q << MOD_STEP_BITS;
      end
    end

    assign bkt_in         = '0;
    assign bkt_cur        = rem_q;
    assign sts_o.fast     = 1'b0;
    assign sts_o.mod_done = (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1));
  end

  // Clearing pass over the fill fields
  logic [BKT_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clr_done = (clr_q == BKT_W'(NUM_BUCKETS - 1));

  // Bucket row memory: fill, values, keys
  logic             ram_we;
  logic [BKT_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_new;
  logic             wr_row;

  assign ram_we    = cmd_i.clr || (cmd_i.commit && wr_row);
  assign ram_waddr = cmd_i.clr ? clr_q : bkt_cur;
  assign ram_wdata = cmd_i.clr ? '0 : row_new;

  hbt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_fast || cmd_i.rd),
    .raddr_i (cmd_i.rd_fast ? bkt_in : bkt_cur),
    .rdata_o (row)
  );

  // Compare all ways, build the written-back row
  logic [FILL_W-1:0]      fill;
  logic [BUCKET_WAYS-1:0] match;
  logic [WAY_W-1:0]       way;
  logic                   hit;
  logic                   full;
  logic                   append;
  logic [VAL_W-1:0]       hit_value;

  always_comb begin
    fill = row[FOFF +: FILL_W];
    if (fill > FILL_W'(BUCKET_WAYS)) fill = FILL_W'(BUCKET_WAYS);
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      match[w] = (FILL_W'(w) < fill) && (row[w*KEY_W +: KEY_W] == key_q);
    end
    way = '0;
    for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
      if (match[w]) way = WAY_W'(w);
    end
    hit       = |match;
    full      = (fill == FILL_W'(BUCKET_WAYS));
    append    = (func_q == FUNC_INSERT) && !hit && !full;
    hit_value = row[VOFF + int'(way)*VAL_W +: VAL_W];
    wr_row    = (func_q == FUNC_INSERT) && (hit || !full);

    row_new = row;
    if (hit) begin
      row_new[VOFF + int'(way)*VAL_W +: VAL_W] = value_q;
    end else begin
      row_new[int'(fill[WAY_W-1:0])*KEY_W +: KEY_W]        = key_q;
      row_new[VOFF + int'(fill[WAY_W-1:0])*VAL_W +: VAL_W] = value_q;
      row_new[FOFF +: FILL_W]                              = fill + 1'b1;
    end
  end

  // Entry count
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit && append) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Result register
  logic              out_valid_q;
  logic              hit_q;
  logic              rej_q;
  logic [VAL_W-1:0]  rdval_q;
  logic [BIDX_W-1:0] bidx_q;
  logic [KEY_W-1:0]  bkt_ext;
  logic [KEY_W-1:0]  cnt_ext;

  assign bkt_ext = KEY_W'(bkt_cur);
  assign cnt_ext = KEY_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q   <= hit;
      rej_q   <= (func_q == FUNC_INSERT) && !hit && full;
      rdval_q <= ((func_q == FUNC_LOOKUP) && hit) ? hit_value : MISS_VALUE;
      bidx_q  <= bkt_ext[BIDX_W-1:0];
    end
  end

  assign sts_o.out_stall    = out_valid_q && !out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_hit_o            = hit_q;
  assign out_read_value_o     = rdval_q;
  assign out_rejected_o       = rej_q;
  assign out_bucket_index_o   = bidx_q;
  assign out_entries_stored_o = cnt_ext[COUNT_W-1:0];

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOTS))
    else $error("entry count above table capacity");

  ap_hit_xor_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && rej_q))
    else $error("result both hit and rejected");

  ap_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  ap_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |-> !cmd_i.commit && !cmd_i.rd_fast && !cmd_i.rd)
    else $error("row access during clearing pass");

endmodule

// ===== rtl/core/bucketed_hash_table_top.sv =====
// Bucketed key/value store: NUM_BUCKETS buckets of BUCKET_WAYS 32-bit key/value
// pairs, bucket = key mod NUM_BUCKETS. A lookup returns the stored value with hit
// set, or -1 with hit clear; an insert updates a known key, appends a new one, or
// reports rejected when the bucket is full. Each operation reads one bucket row
// from a row memory with separate read and write ports, compares all ways at
// once, and writes the row back, one operation at a time. When NUM_BUCKETS is
// not a power of two, the key remainder (8 key bits per cycle) and a separate
// row read come before the compare. After reset the block runs a clearing pass
// over all NUM_BUCKETS bucket fills, with s_axis_tready low. Slots never
// written are not read. A finished result waits in an output register, so
// the next transaction can be accepted while m_axis_tready is low.
module bucketed_hash_table_top import hbt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_WAYS = BUCKET_WAYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // read_value[31:0], bucket_index[35:32],
                                      // entries_stored[43:36], zero[47:44]
  output logic [1:0]  m_axis_tuser    // hit[0], rejected[1]
);

  hbt_cmd_t          cmd;
  hbt_sts_t          sts;
  logic              hit;
  logic              rejected;
  logic [VAL_W-1:0]  read_value;
  logic [BIDX_W-1:0] bucket_index;
  logic [COUNT_W-1:0] entries_stored;

  hbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hbt_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_WAYS (BUCKET_WAYS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_func_i            (s_axis_tuser[0]),
    .in_key_i             (s_axis_tdata[31:0]),
    .in_value_i           (s_axis_tdata[63:32]),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_hit_o            (hit),
    .out_read_value_o     (read_value),
    .out_rejected_o       (rejected),
    .out_bucket_index_o   (bucket_index),
    .out_entries_stored_o (entries_stored)
  );

  assign m_axis_tdata = {4'b0000, entries_stored, bucket_index, read_value};
  assign m_axis_tuser = {rejected, hit};

endmodule

// ===== dv/bucketed_hash_table_checker.sv =====
`timescale 1ns / 100ps

module bucketed_hash_table_checker import hbt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_WAYS = BUCKET_WAYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [63:0] s_data_i,     // key[31:0], value[63:32]
  input  logic [0:0]  s_user_i,     // func[0]
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [47:0] m_data_i,     // read_value[31:0], bucket_index[35:32],
                                    // entries_stored[43:36], zero[47:44]
  input  logic [1:0]  m_user_i,     // hit[0], rejected[1]
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic               hit;
    logic [VAL_W-1:0]   read_value;
    logic               rejected;
    logic [BIDX_W-1:0]  bucket;
    logic [COUNT_W-1:0] entries;
  } table_result_t;

  logic [KEY_W-1:0] key_store   [NUM_BUCKETS][BUCKET_WAYS];
  logic [VAL_W-1:0] value_store [NUM_BUCKETS][BUCKET_WAYS];
  int unsigned      bucket_fill [NUM_BUCKETS];
  int unsigned      entry_total;
  table_result_t    pending_results [$];
  table_result_t    oldest;

  // Apply one operation to the shadow table and return what the block must report
  function automatic table_result_t hash_table_apply(input logic func,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VAL_W-1:0] value);
    table_result_t res;
    int unsigned   bucket;
    int unsigned   way;
    bit            found;
    bucket = key % NUM_BUCKETS;
    found  = 1'b0;
    way    = 0;
    res.read_value = MISS_VALUE;
    res.rejected   = 1'b0;
    for (int i = 0; i < bucket_fill[bucket]; i++) begin
      if (!found && key_store[bucket][i] == key) begin
        found = 1'b1;
        way   = i;
      end
    end
    if (func == FUNC_LOOKUP) begin
      if (found) res.read_value = value_store[bucket][way];
    end else if (found) begin
      value_store[bucket][way] = value;
    end else if (bucket_fill[bucket] < BUCKET_WAYS) begin
      key_store[bucket][bucket_fill[bucket]]   = key;
      value_store[bucket][bucket_fill[bucket]] = value;
      bucket_fill[bucket]++;
      entry_total++;
    end else begin
      res.rejected = 1'b1;
    end
    res.hit     = found;
    res.bucket  = bucket[BIDX_W-1:0];
    res.entries = entry_total[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bucket_fill[b]) bucket_fill[b] = 0;
      entry_total  = 0;
      fail_count_o = 0;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result without pending transaction", 64'(m_data_i), '0);
        end else begin
          oldest = pending_results.pop_front();
          if (m_user_i[0] !== oldest.hit)
            report_mismatch("hit", 64'(m_user_i[0]), 64'(oldest.hit));
          if (m_user_i[1] !== oldest.rejected)
            report_mismatch("rejected", 64'(m_user_i[1]), 64'(oldest.rejected));
          if (m_data_i[31:0] !== oldest.read_value)
            report_mismatch("read_value", 64'(m_data_i[31:0]), 64'(oldest.read_value));
          if (m_data_i[35:32] !== oldest.bucket)
            report_mismatch("bucket_index", 64'(m_data_i[35:32]), 64'(oldest.bucket));
          if (m_data_i[43:36] !== oldest.entries)
            report_mismatch("entries_stored", 64'(m_data_i[43:36]), 64'(oldest.entries));
          if (m_data_i[47:44] !== 4'd0)
            report_mismatch("padding", 64'(m_data_i[47:44]), '0);
        end
      end
      if (s_valid_i && s_ready_i)
        pending_results.push_back(hash_table_apply(s_user_i[0], s_data_i[31:0],
                                                   s_data_i[63:32]));
      pending_o <= pending_results.size();
    end
  end

endmodule

// ===== dv/bucketed_hash_table_top_test.sv =====
`timescale 1ns / 100ps

module bucketed_hash_table_top_test;
  import hbt_pkg::*;

  localparam int unsigned PHASE_ITEMS = 460;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned POOL_SIZE   = 64;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // key[31:0], value[63:32]
  logic [0:0]  s_axis_tuser  = '0;   // func[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // read_value[31:0], bucket_index[35:32],
                                     // entries_stored[43:36], zero[47:44]
  logic [1:0]  m_axis_tuser;         // hit[0], rejected[1]

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tx_idle_pct = 24;
  int unsigned rx_idle_pct = 62;
  int unsigned phase       = 0;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned quiet_cycles;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  bucketed_hash_table_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bucketed_hash_table_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random backpressure, plus one long hold-off in the last phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned      pick;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    pick = $urandom_range(0, 99);
    func = 1'($urandom_range(0, 1));
    if (pick < 60)      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (pick < 80) key = $urandom;
    else                key = $urandom_range(0, 300);
    case ($urandom_range(0, 19))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = 32'hffff_ffff;
      3:       value = 32'h0000_0000;
      default: value = $urandom;
    endcase
    // Feed fresh keys into the pool so later lookups and updates can hit them
    if (pick >= 60 && func == FUNC_INSERT && $urandom_range(0, 3) == 0)
      key_pool[$urandom_range(0, POOL_SIZE - 1)] = key;
    send_item(func, key, value);
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, extreme keys and values, and a stored value of all ones
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send_item(FUNC_INSERT, 32'h0000_0000, 32'h8000_0000);
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'hffff_ffff);
    send_item(FUNC_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(FUNC_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    send_item(FUNC_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
    // Fill one bucket, then overflow it with a new key and update a known one
    for (int i = 0; i < 8; i++)
      send_item(FUNC_INSERT, 32'd3 + 32'd16 * i, $urandom);
    send_item(FUNC_INSERT, 32'd3 + 32'd16 * 8, 32'h5555_aaaa);
    send_item(FUNC_LOOKUP, 32'd3 + 32'd16 * 8, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'd3 + 32'd16 * 2, 32'haaaa_5555);
    send_item(FUNC_LOOKUP, 32'd3 + 32'd16 * 2, $urandom);
    send_item(FUNC_LOOKUP, 32'hffff_fff3, 32'h0000_0000);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct <= 24;
          rx_idle_pct <= 62;
        end
        1: begin
          tx_idle_pct <= 62;
          rx_idle_pct <= 24;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      phase <= p;
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    // Every accepted transaction must have produced its result by now
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
